### sv/emap_pkg.sv
// Shared types for the extent map allocator.
// No dependencies.
package emap_pkg;

    typedef struct packed {
        logic [31:0] len;
        logic [31:0] start;
    } ext_t;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

endpackage

### sv/emap_table.sv
// Extent table memory: one write port, one registered read port.
// Depends on emap_pkg.
module emap_table #(
    parameter int TABLE_SLOTS = 64
) (
    input  logic                           clk,
    input  logic                           rd_en,
    input  logic [$clog2(TABLE_SLOTS)-1:0] rd_addr,
    output emap_pkg::ext_t                 rd_data,
    input  logic                           wr_en,
    input  logic [$clog2(TABLE_SLOTS)-1:0] wr_addr,
    input  emap_pkg::ext_t                 wr_data
);
    import emap_pkg::*;

    ext_t mem [TABLE_SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### sv/emap_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on emap_pkg.
module emap_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    import emap_pkg::*;

    logic [32:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] dvs_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;
    logic [32:0] shifted;

    assign shifted = {rem_reg[31:0], quo_reg[31]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == 6'd1);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### sv/extent_map_allocator_core.sv
// Extent map allocator top level: sequencer over the extent table and divider.
// Depends on emap_pkg, emap_table, emap_div.
//
//  channel | signals                      | dir | payload
//  s       | s_tvalid s_tready s_tdata    | in  | address, size, alignment; tuser kind
//  m       | m_tvalid m_tready m_tdata    | out | granted_address, extent_lost, extent_count
//  cfg     | cfg_valid cfg_ready cfg_data | in  | floor_address
//
// One item at a time. A free scans the table entry by entry and shifts or
// removes entries one at a time; an alloc tries extents in turn, and goes
// through the divider when alignment is set. Longest item: an aligned
// alloc that misses on 62 extents, then removes and frees its gap.
// Reset clears control state and empties the table (fill count); no sweep.
// s_tready is low from acceptance until the result has been taken.
module extent_map_allocator_core #(
    parameter int TABLE_SLOTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // address[31:0], size[62:32], alignment[93:63], zeros
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // granted_address[31:0], extent_lost[32], extent_count[38:33]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);
    import emap_pkg::*;

    localparam int IW  = $clog2(TABLE_SLOTS);
    localparam int CW  = $clog2(TABLE_SLOTS + 1);
    localparam int CAP = TABLE_SLOTS - 1;

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_FST   = 15'b000000000000010,
        S_FRD   = 15'b000000000000100,
        S_FCHK  = 15'b000000000001000,
        S_FDEC  = 15'b000000000010000,
        S_SURD  = 15'b000000000100000,
        S_SUWR  = 15'b000000001000000,
        S_RMRD  = 15'b000000010000000,
        S_RMWR  = 15'b000000100000000,
        S_ARD   = 15'b000001000000000,
        S_ACHK  = 15'b000010000000000,
        S_ADIV  = 15'b000100000000000,
        S_AFIT  = 15'b001000000000000,
        S_AGAP  = 15'b010000000000000,
        S_DONE  = 15'b100000000000000
    } state_t;

    state_t         state_reg;
    logic [31:0]    floor_reg;
    logic [31:0]    addr_reg, size_reg, align_reg, grant_reg;
    logic [CW-1:0]  count_reg;
    logic [IW-1:0]  idx_reg, k_reg, k2_reg;
    ext_t           prev_reg, cur_reg, new_reg;
    logic           has_prev_reg, cur_valid_reg, rm2_reg, to_gap_reg;
    logic           ok_reg, lost_reg, inc_reg;
    logic           out_valid_reg;
    logic [39:0]    out_data_reg;
    logic           div_go_reg;

    logic           rd_en, wr_en;
    logic [IW-1:0]  rd_addr, wr_addr;
    ext_t           rd_data, wr_data;
    logic           div_done;
    logic [31:0]    div_quo;
    logic [63:0]    prod;

    emap_table #(.TABLE_SLOTS(TABLE_SLOTS)) u_table (
        .clk(clk), .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
    );

    // start is registered from the candidate choice, so the dividend sees grant_reg
    emap_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_go_reg),
        .dividend(grant_reg + align_reg - 32'd1), .divisor(align_reg),
        .done(div_done), .quotient(div_quo)
    );

    assign prod      = div_quo * align_reg;
    assign s_tready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // combinational helpers for the merge decision and the alloc fit
    logic [31:0] merge_len, up_len, fit_room, new_len, gap_len;
    logic        merge_dn, merge_up;
    logic        achk_skip, achk_stop;
    assign merge_dn  = has_prev_reg && (prev_reg.start + prev_reg.len == addr_reg);
    assign merge_up  = cur_valid_reg && (addr_reg + size_reg == cur_reg.start);
    assign merge_len = prev_reg.len + size_reg + (merge_up ? cur_reg.len : 32'd0);
    assign up_len    = cur_reg.len + size_reg;
    assign fit_room  = cur_reg.start + cur_reg.len - grant_reg;
    assign new_len   = cur_reg.len - (grant_reg - cur_reg.start + size_reg);
    assign gap_len   = grant_reg - cur_reg.start;
    // wanted address: skip extents above it, give up on the first one that is too short
    assign achk_skip = (addr_reg != 32'd0) && (rd_data.start > addr_reg);
    assign achk_stop = (addr_reg != 32'd0)
                       && (addr_reg + size_reg > rd_data.start + rd_data.len);

    always_comb
    begin
        rd_en     = 1'b0;
        rd_addr   = idx_reg;
        wr_en     = 1'b0;
        wr_addr   = idx_reg;
        wr_data   = new_reg;
        case (state_reg)
            S_FRD, S_ARD:
            begin
                rd_en = (CW'(idx_reg) != count_reg);
            end
            S_FDEC:
            begin
                if (merge_dn)
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_reg - IW'(1);
                    wr_data = '{len: merge_len, start: prev_reg.start};
                end
                else if (merge_up)
                begin
                    wr_en   = 1'b1;
                    wr_data = '{len: up_len, start: cur_reg.start - size_reg};
                end
            end
            S_SURD:
            begin
                if (k_reg == idx_reg)
                begin
                    wr_en = 1'b1;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = k_reg - IW'(1);
                end
            end
            S_SUWR:
            begin
                wr_en   = 1'b1;
                wr_addr = k_reg;
                wr_data = rd_data;
            end
            S_RMRD:
            begin
                rd_en   = (CW'(k_reg) + CW'(1) < count_reg);
                rd_addr = k_reg + IW'(1);
            end
            S_RMWR:
            begin
                wr_en   = 1'b1;
                wr_addr = k_reg;
                wr_data = rd_data;
            end
            S_AFIT:
            begin
                wr_en   = (fit_room >= size_reg);
                wr_data = '{len: new_len, start: grant_reg + size_reg};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_go_reg <= 1'b0;
        end
        else
        begin
            div_go_reg <= (state_reg == S_ACHK) && !achk_skip && !achk_stop
                          && (align_reg != 32'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            floor_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                floor_reg <= cfg_data;
            end
            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        addr_reg  <= s_tdata[31:0];
                        size_reg  <= {1'b0, s_tdata[62:32]};
                        align_reg <= {1'b0, s_tdata[93:63]};
                        ok_reg    <= 1'b0;
                        lost_reg  <= 1'b0;
                        idx_reg   <= '0;
                        state_reg <= (s_tuser == KIND_FREE) ? S_FST : S_ARD;
                    end
                end
                S_FST:
                begin
                    idx_reg      <= '0;
                    has_prev_reg <= 1'b0;
                    to_gap_reg   <= 1'b0;
                    state_reg    <= (size_reg == 32'd0 || addr_reg <= floor_reg)
                                    ? S_DONE : S_FRD;
                end
                S_FRD:
                begin
                    if (CW'(idx_reg) == count_reg)
                    begin
                        cur_valid_reg <= 1'b0;
                        state_reg     <= S_FDEC;
                    end
                    else
                    begin
                        state_reg <= S_FCHK;
                    end
                end
                S_FCHK:
                begin
                    if (rd_data.start <= addr_reg)
                    begin
                        prev_reg     <= rd_data;
                        has_prev_reg <= 1'b1;
                        idx_reg      <= idx_reg + IW'(1);
                        state_reg    <= S_FRD;
                    end
                    else
                    begin
                        cur_reg       <= rd_data;
                        cur_valid_reg <= 1'b1;
                        state_reg     <= S_FDEC;
                    end
                end
                S_FDEC:
                begin
                    new_reg <= '{len: size_reg, start: addr_reg};
                    if (merge_dn)
                    begin
                        if (merge_up)
                        begin
                            k_reg     <= idx_reg;
                            k2_reg    <= idx_reg - IW'(1);
                            rm2_reg   <= (merge_len == 32'd0);
                            state_reg <= S_RMRD;
                        end
                        else if (merge_len == 32'd0)
                        begin
                            k_reg     <= idx_reg - IW'(1);
                            rm2_reg   <= 1'b0;
                            state_reg <= S_RMRD;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                    else if (merge_up)
                    begin
                        k_reg     <= idx_reg;
                        rm2_reg   <= 1'b0;
                        state_reg <= (up_len == 32'd0) ? S_RMRD : S_DONE;
                    end
                    else if (count_reg < CW'(CAP))
                    begin
                        k_reg     <= count_reg[IW-1:0];
                        inc_reg   <= 1'b1;
                        state_reg <= S_SURD;
                    end
                    else
                    begin
                        lost_reg  <= 1'b1;
                        k_reg     <= IW'(CAP - 1);
                        inc_reg   <= 1'b0;
                        state_reg <= (CW'(idx_reg) < CW'(CAP)) ? S_SURD : S_DONE;
                    end
                end
                S_SURD:
                begin
                    if (k_reg == idx_reg)
                    begin
                        if (inc_reg)
                        begin
                            count_reg <= count_reg + CW'(1);
                        end
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_SUWR;
                    end
                end
                S_SUWR:
                begin
                    k_reg     <= k_reg - IW'(1);
                    state_reg <= S_SURD;
                end
                S_RMRD:
                begin
                    if (CW'(k_reg) + CW'(1) < count_reg)
                    begin
                        state_reg <= S_RMWR;
                    end
                    else
                    begin
                        count_reg <= count_reg - CW'(1);
                        if (rm2_reg)
                        begin
                            rm2_reg <= 1'b0;
                            k_reg   <= k2_reg;
                        end
                        else
                        begin
                            state_reg <= to_gap_reg ? S_AGAP : S_DONE;
                        end
                    end
                end
                S_RMWR:
                begin
                    k_reg     <= k_reg + IW'(1);
                    state_reg <= S_RMRD;
                end
                S_ARD:
                begin
                    state_reg <= (CW'(idx_reg) == count_reg) ? S_DONE : S_ACHK;
                end
                S_ACHK:
                begin
                    cur_reg <= rd_data;
                    if (achk_skip)
                    begin
                        idx_reg   <= idx_reg + IW'(1);
                        state_reg <= S_ARD;
                    end
                    else if (achk_stop)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        grant_reg <= (addr_reg != 32'd0) ? addr_reg : rd_data.start;
                        state_reg <= (align_reg != 32'd0) ? S_ADIV : S_AFIT;
                    end
                end
                S_ADIV:
                begin
                    if (div_done)
                    begin
                        grant_reg <= prod[31:0];
                        state_reg <= S_AFIT;
                    end
                end
                S_AFIT:
                begin
                    if (fit_room < size_reg)
                    begin
                        idx_reg   <= idx_reg + IW'(1);
                        state_reg <= S_ARD;
                    end
                    else
                    begin
                        ok_reg     <= 1'b1;
                        k_reg      <= idx_reg;
                        rm2_reg    <= 1'b0;
                        to_gap_reg <= 1'b1;
                        state_reg  <= (new_len == 32'd0) ? S_RMRD : S_AGAP;
                    end
                end
                S_AGAP:
                begin
                    // gaps of 2^31 or more are dropped silently
                    addr_reg  <= cur_reg.start;
                    size_reg  <= gap_len;
                    state_reg <= (gap_len != 32'd0 && !gap_len[31]) ? S_FST : S_DONE;
                end
                S_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    out_data_reg  <= {1'b0, count_reg[5:0], lost_reg,
                                      (ok_reg ? grant_reg : 32'd0)};
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (state_reg == S_IDLE))
        else $error("result pending outside idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAP))
        else $error("extent count beyond capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADIV) |-> (align_reg != 32'd0))
        else $error("division with zero divisor");

endmodule
